### hdl/misp_timestamp_extractor_assert.svh
// Assertion macros shared by the timestamp extractor modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef MISP_TIMESTAMP_EXTRACTOR_ASSERT_SVH
`define MISP_TIMESTAMP_EXTRACTOR_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define MTS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define MTS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/misp_ts_pkg.sv
package misp_ts_pkg;

  // Tag and field geometry
  localparam int TAG_BYTES   = 16;
  localparam int FIELD_BYTES = 12;
  localparam int WINDOW_W    = TAG_BYTES * 8;
  localparam int FILL_W      = $clog2(TAG_BYTES + 1);
  localparam int POS_W       = $clog2(FIELD_BYTES);
  localparam int TIME_W      = 64;
  localparam int CFG_W       = 64;
  localparam int CFG_INDEX_W = 3;

  // Every third field byte is a guard byte
  localparam logic [1:0] PHASE_LAST  = 2'd2;
  localparam logic [1:0] GUARD_PHASE = 2'd2;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TAG_MODE    = 3'd0,
    CFG_STRING_HIGH = 3'd1,
    CFG_STRING_LOW  = 3'd2,
    CFG_MICRO_HIGH  = 3'd3,
    CFG_MICRO_LOW   = 3'd4,
    CFG_NANO_HIGH   = 3'd5,
    CFG_NANO_LOW    = 3'd6
  } cfg_index_t;

  // Parser state
  typedef enum logic [1:0] {
    FS_HUNT,
    FS_STATUS,
    FS_FIELD
  } front_state_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_ns;
    logic [7:0]        status_byte;
    logic              was_nano;
  } out_item_t;

  // Parsed packet waiting for scaling
  typedef struct packed {
    logic [TIME_W-1:0] count;
    logic [7:0]        status_byte;
    logic              was_nano;
  } job_t;

  typedef struct packed {
    logic             tag_mode;
    logic [CFG_W-1:0] string_tag_high;
    logic [CFG_W-1:0] string_tag_low;
    logic [CFG_W-1:0] micro_uuid_high;
    logic [CFG_W-1:0] micro_uuid_low;
    logic [CFG_W-1:0] nano_uuid_high;
    logic [CFG_W-1:0] nano_uuid_low;
  } cfg_t;

endpackage

### hdl/misp_ts_front.sv
`include "misp_timestamp_extractor_assert.svh"

module misp_ts_front
  import misp_ts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     push,
  output job_t     push_data
);

  front_state_t          state_r, state_nxt;
  logic [WINDOW_W-1:0]   win_r, win_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [1:0]            phase_r, phase_nxt;
  logic [TIME_W-1:0]     acc_r, acc_nxt;
  logic [7:0]            status_r, status_nxt;
  logic                  nano_r, nano_nxt;

  logic                  fire;
  logic [WINDOW_W-1:0]   win_shift;
  logic                  win_full;
  logic                  str_match, micro_match, nano_match;
  logic                  hit, nano_hit;
  logic                  last_pos;

  // Accept while the queue has room
  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  // Window compare on the shifted-in byte
  assign win_shift   = {win_r[WINDOW_W-9:0], in_data.byte_in};
  assign win_full    = fill_r >= FILL_W'(TAG_BYTES - 1);
  assign str_match   = win_shift == {cfg.string_tag_high, cfg.string_tag_low};
  assign micro_match = win_shift == {cfg.micro_uuid_high, cfg.micro_uuid_low};
  assign nano_match  = win_shift == {cfg.nano_uuid_high, cfg.nano_uuid_low};
  assign hit      = win_full && (cfg.tag_mode ? (nano_match || micro_match) : str_match);
  assign nano_hit = cfg.tag_mode && nano_match;
  assign last_pos = pos_r == POS_W'(FIELD_BYTES - 1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    if (fire) begin
      unique case (state_r)
        FS_HUNT:   if (hit) state_nxt = FS_STATUS;
        FS_STATUS: state_nxt = FS_FIELD;
        FS_FIELD:  if (last_pos) state_nxt = FS_HUNT;
        default:   state_nxt = FS_HUNT;
      endcase
      if (in_data.buffer_end) state_nxt = FS_HUNT;
    end
  end

  // Datapath and queue push
  always_comb begin
    win_nxt    = win_r;
    fill_nxt   = fill_r;
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    status_nxt = status_r;
    nano_nxt   = nano_r;
    push       = 1'b0;
    if (fire) begin
      unique case (state_r)
        FS_HUNT: begin
          win_nxt = win_shift;
          if (hit) begin
            fill_nxt = '0;
            acc_nxt  = '0;
            nano_nxt = nano_hit;
          end else if (fill_r != FILL_W'(TAG_BYTES)) begin
            fill_nxt = fill_r + FILL_W'(1);
          end
        end
        FS_STATUS: begin
          status_nxt = in_data.byte_in;
          pos_nxt    = '0;
          phase_nxt  = '0;
        end
        FS_FIELD: begin
          // drop guard bytes, shift the rest in big-endian
          if (phase_r != GUARD_PHASE) acc_nxt = {acc_r[TIME_W-9:0], in_data.byte_in};
          phase_nxt = (phase_r == PHASE_LAST) ? 2'd0 : phase_r + 2'd1;
          pos_nxt   = pos_r + POS_W'(1);
          push      = last_pos;
        end
        default: ;
      endcase
      if (in_data.buffer_end) fill_nxt = '0;
    end
  end

  assign push_data.count       = acc_nxt;
  assign push_data.status_byte = status_r;
  assign push_data.was_nano    = nano_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_HUNT;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    win_r    <= win_nxt;
    pos_r    <= pos_nxt;
    phase_r  <= phase_nxt;
    acc_r    <= acc_nxt;
    status_r <= status_nxt;
    nano_r   <= nano_nxt;
  end

  `MTS_ASSERT_IMPLIES(a_empty_window_in_capture, state_r != FS_HUNT, fill_r == '0, "window not empty during capture")
  `MTS_ASSERT_IMPLIES(a_push_has_room, push, !q_full, "push into full queue")
  `MTS_ASSERT_NEXT(a_hunt_after_push, push, state_r == FS_HUNT, "capture did not end after push")

endmodule

### hdl/misp_ts_queue.sv
`include "misp_timestamp_extractor_assert.svh"

module misp_ts_queue
  import misp_ts_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = count_r == CNT_W'(DEPTH);
  assign not_empty = count_r != '0;
  assign head      = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    if (push && !pop)      count_nxt = count_r + CNT_W'(1);
    else if (pop && !push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  `MTS_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(DEPTH), "queue count past depth")
  `MTS_ASSERT_IMPLIES(a_pop_not_empty, pop, not_empty, "pop from empty queue")

endmodule

### hdl/misp_ts_back.sv
module misp_ts_back
  import misp_ts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  job_t      q_head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r;
  logic [TIME_W-1:0] scaled;

  // Microseconds to nanoseconds: x*1000 = x*1024 - x*16 - x*8, modulo 2^64
  assign scaled = {q_head.count[TIME_W-11:0], 10'b0}
                - {q_head.count[TIME_W-5:0], 4'b0}
                - {q_head.count[TIME_W-4:0], 3'b0};

  // Load the output register when it is free or being taken
  assign pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop)            out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r.time_ns     <= q_head.was_nano ? q_head.count : scaled;
      out_r.status_byte <= q_head.status_byte;
      out_r.was_nano    <= q_head.was_nano;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### hdl/misp_timestamp_extractor.sv
// Timestamp tag parser for a metadata byte stream.
// Input channel (in_valid/in_ready/in_data): one byte per item, with
// buffer_end marking the last byte of a buffer. Bytes slide through a
// 16-byte window that is compared against the string tag, or against the
// microsecond and nanosecond UUID tags, per the tag mode register.
// After a match, a status byte and 12 timestamp bytes follow; every third
// timestamp byte is a guard and is dropped. Microsecond counts are scaled
// by 1000 modulo 2^64. An unfinished packet is dropped at buffer end.
// Output channel (out_valid/out_ready/out_data): one item per packet.
// Throughput: one byte per cycle while in_ready is high, set by the combinational window compare.
// The edge that accepts the last timestamp byte writes the result into the
// queue; the output register loads it when it is free or being taken.
// Configuration (cfg_we/cfg_index/cfg_wdata) writes the register selected by cfg_index.
// Reset clears the configuration and control registers and empties the window; the parser starts hunting.
// When out_ready stays low, results gather in a short queue; once it is
// full, in_ready drops until the receiver takes a result.
module misp_timestamp_extractor
  import misp_ts_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;
  logic q_full, q_not_empty, push, pop;
  job_t push_data, q_head;

  // Register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_TAG_MODE:    cfg_nxt.tag_mode        = cfg_wdata[0];
        CFG_STRING_HIGH: cfg_nxt.string_tag_high = cfg_wdata;
        CFG_STRING_LOW:  cfg_nxt.string_tag_low  = cfg_wdata;
        CFG_MICRO_HIGH:  cfg_nxt.micro_uuid_high = cfg_wdata;
        CFG_MICRO_LOW:   cfg_nxt.micro_uuid_low  = cfg_wdata;
        CFG_NANO_HIGH:   cfg_nxt.nano_uuid_high  = cfg_wdata;
        CFG_NANO_LOW:    cfg_nxt.nano_uuid_low   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else        cfg_r <= cfg_nxt;
  end

  misp_ts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  misp_ts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  misp_ts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
